/* sv/uvs_pkg.sv */
// ---------------------------------------------------------------------------
// uvs_pkg: shared types and constants of the UV-sphere vertex generator
// Field widths, CORDIC tables, result records and rounding helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package uvs_pkg;

  // default grid index width
  localparam int GRID_BITS_DEF = 10;

  // fixed field widths
  localparam int POS_W  = 16;
  localparam int TEX_W  = 17;
  localparam int IDX_W  = 20;
  localparam int ANG_W  = 32;

  // CORDIC datapath
  localparam int CORDIC_STEPS = 30;
  localparam int CW           = 33;
  localparam int PROD_W       = 2 * CW;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;

  // configuration register reset values
  localparam int STACK_RESET = 16;
  localparam int SLICE_RESET = 32;

  // binary-angle arctangent table, one full turn = 2^32
  function automatic logic [31:0] atan_turn(input int k);
    logic [31:0] t;
    case (k)
      0:  t = 32'd536870912;
      1:  t = 32'd316933406;
      2:  t = 32'd167458907;
      3:  t = 32'd85004756;
      4:  t = 32'd42667331;
      5:  t = 32'd21354465;
      6:  t = 32'd10679838;
      7:  t = 32'd5340245;
      8:  t = 32'd2670163;
      9:  t = 32'd1335087;
      10: t = 32'd667544;
      11: t = 32'd333772;
      12: t = 32'd166886;
      13: t = 32'd83443;
      14: t = 32'd41722;
      15: t = 32'd20861;
      16: t = 32'd10430;
      17: t = 32'd5215;
      18: t = 32'd2608;
      19: t = 32'd1304;
      20: t = 32'd652;
      21: t = 32'd326;
      22: t = 32'd163;
      23: t = 32'd81;
      24: t = 32'd41;
      25: t = 32'd20;
      26: t = 32'd10;
      27: t = 32'd5;
      28: t = 32'd3;
      29: t = 32'd1;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

  // round half up by sh bits (floor), clamp to +-1.0 in Q1.14
  function automatic logic [POS_W-1:0] round_q14(input logic signed [PROD_W-1:0] v,
                                                 input int sh);
    logic signed [PROD_W-1:0] half;
    logic signed [PROD_W-1:0] t;
    half = '0;
    half[sh-1] = 1'b1;
    t = (v + half) >>> sh;
    if (t > 66'sd16384) t = 66'sd16384;
    else if (t < -66'sd16384) t = -66'sd16384;
    return t[POS_W-1:0];
  endfunction

  // index and flag sideband
  typedef struct packed {
    logic [IDX_W-1:0] vnum;
    logic [IDX_W-1:0] qlow;
    logic             qvalid;
    logic             oor;
  } side_t;

  // texture coordinate sideband
  typedef struct packed {
    logic [TEX_W-1:0] u;
    logic [TEX_W-1:0] v;
  } tex_t;

  // one result record
  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
    logic [IDX_W-1:0] vertex_number;
    logic [IDX_W-1:0] quad_upper;
    logic [IDX_W-1:0] quad_lower;
    logic             quad_valid;
    logic             out_of_range;
  } rsp_t;

endpackage

`default_nettype wire

/* sv/uvs_if.sv */
// ---------------------------------------------------------------------------
// uvs_if: request and result channels of the vertex generator
// Valid/ready channels; a transfer happens when valid and ready are high.
// ---------------------------------------------------------------------------
`default_nettype none

interface uvs_req_if #(parameter int GRID_BITS = uvs_pkg::GRID_BITS_DEF);
  logic                 valid;
  logic                 ready;
  logic [GRID_BITS-1:0] stack_index;
  logic [GRID_BITS-1:0] slice_index;
  modport source(output valid, stack_index, slice_index, input ready);
  modport sink(input valid, stack_index, slice_index, output ready);
endinterface

interface uvs_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [uvs_pkg::POS_W-1:0]    pos_x;
  logic [uvs_pkg::POS_W-1:0]    pos_y;
  logic [uvs_pkg::POS_W-1:0]    pos_z;
  logic [uvs_pkg::TEX_W-1:0]    tex_u;
  logic [uvs_pkg::TEX_W-1:0]    tex_v;
  logic [uvs_pkg::IDX_W-1:0]    vertex_number;
  logic [uvs_pkg::IDX_W-1:0]    quad_upper;
  logic [uvs_pkg::IDX_W-1:0]    quad_lower;
  logic                         quad_valid;
  logic                         out_of_range;
  modport source(output valid, pos_x, pos_y, pos_z, tex_u, tex_v, vertex_number,
                 quad_upper, quad_lower, quad_valid, out_of_range, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, tex_u, tex_v, vertex_number,
               quad_upper, quad_lower, quad_valid, out_of_range, output ready);
endinterface

`default_nettype wire

/* sv/uvs_recip.sv */
// ---------------------------------------------------------------------------
// uvs_recip: serial reciprocal setup for the grid counts
// Long-divides 2^m by 2*count one bit per cycle and latches the quotient and
// remainder at the powers the index lanes need.
// ---------------------------------------------------------------------------
`default_nettype none

module uvs_recip #(
  parameter int GRID_BITS = uvs_pkg::GRID_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [GRID_BITS-1:0]   stack_eff,
  input  wire logic [GRID_BITS-1:0]   slice_eff,
  output logic                        busy,
  output logic [31:0]                 st_qhi,
  output logic [GRID_BITS:0]          st_rhi,
  output logic [uvs_pkg::TEX_W-1:0]   st_qtex,
  output logic [GRID_BITS:0]          st_rtex,
  output logic [2*GRID_BITS+1:0]      st_m,
  output logic [31:0]                 sl_qhi,
  output logic [GRID_BITS:0]          sl_rhi,
  output logic [uvs_pkg::TEX_W-1:0]   sl_qtex,
  output logic [GRID_BITS:0]          sl_rtex,
  output logic [2*GRID_BITS+1:0]      sl_m
);

  localparam int G    = GRID_BITS;
  localparam int S    = 2 * G + 2;
  localparam int MTOP = (S > 33) ? S : 33;
  localparam int MW   = $clog2(MTOP + 1);
  localparam int QW   = MTOP + 1;

  // sequencer codes
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_STACK = 2'd1;
  localparam logic [1:0] ST_SLICE = 2'd2;

  logic [1:0]    state;
  logic [MW-1:0] m;
  logic [QW-1:0] q;
  logic [G+1:0]  rem;
  logic [QW-1:0] q_next;
  logic [G+1:0]  rem_next;
  logic [G:0]    d;
  logic [G+1:0]  r2;

  assign busy = (state != ST_IDLE);
  assign d    = (state == ST_SLICE) ? {slice_eff, 1'b0} : {stack_eff, 1'b0};

  // one restoring step: from 2^m to 2^(m+1)
  always_comb begin
    r2 = {rem[G:0], 1'b0};
    if (r2 >= {1'b0, d}) begin
      rem_next = r2 - {1'b0, d};
      q_next   = {q[QW-2:0], 1'b1};
    end else begin
      rem_next = r2;
      q_next   = {q[QW-2:0], 1'b0};
    end
  end

  // sequencer: stack count, then slice count
  always_ff @(posedge clk) begin
    if (rst || start) begin
      state <= ST_STACK;
      m     <= '0;
      q     <= '0;
      rem   <= (G+2)'(1);
    end else begin
      unique case (state)
        ST_STACK, ST_SLICE: begin
          if (m == MW'(MTOP)) begin
            m     <= '0;
            q     <= '0;
            rem   <= (G+2)'(1);
            state <= (state == ST_STACK) ? ST_SLICE : ST_IDLE;
          end else begin
            m   <= m + MW'(1);
            q   <= q_next;
            rem <= rem_next;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // latch quotients at the needed powers
  always_ff @(posedge clk) begin
    if (state == ST_STACK) begin
      if (m == MW'(32)) begin
        st_qhi <= q[31:0];
        st_rhi <= rem[G:0];
      end
      if (m == MW'(17)) begin
        st_qtex <= q[uvs_pkg::TEX_W-1:0];
        st_rtex <= rem[G:0];
      end
      if (m == MW'(S)) st_m <= q[S-1:0];
    end
    if (state == ST_SLICE) begin
      if (m == MW'(33)) begin
        sl_qhi <= q[31:0];
        sl_rhi <= rem[G:0];
      end
      if (m == MW'(17)) begin
        sl_qtex <= q[uvs_pkg::TEX_W-1:0];
        sl_rtex <= rem[G:0];
      end
      if (m == MW'(S)) sl_m <= q[S-1:0];
    end
  end

endmodule

`default_nettype wire

/* sv/uvs_quot_lane.sv */
// ---------------------------------------------------------------------------
// uvs_quot_lane: pipelined rounded quotient by a grid count
// out = floor((x*2^k + h) / d) mod 2^W, with 2^k = Q*d + R split so that
// only a narrow remainder is divided, by reciprocal and one correction.
// ---------------------------------------------------------------------------
`default_nettype none

module uvs_quot_lane #(
  parameter int GRID_BITS = uvs_pkg::GRID_BITS_DEF,
  parameter int QW        = 32,
  parameter int W         = 32
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [GRID_BITS-1:0]   x,
  input  wire logic [QW-1:0]          q_mul,
  input  wire logic [GRID_BITS:0]     r_mul,
  input  wire logic [GRID_BITS:0]     d,
  input  wire logic [GRID_BITS-1:0]   h,
  input  wire logic [2*GRID_BITS+1:0] m_mul,
  output logic [W-1:0]                out
);

  localparam int G = GRID_BITS;
  localparam int S = 2 * G + 2;

  logic [G+QW-1:0]  pa;
  logic [2*G:0]     pb;
  logic [2*S-1:0]   pm;
  logic [S+G:0]     pd;
  logic [S-1:0]     diff;
  logic [G+1:0]     rem;

  logic [W-1:0] a1, a2, a3, a4, a5;
  logic [2*G:0] b1;
  logic [S-1:0] n2, n3, n4;
  logic [S-1:0] qe3, qe4;
  logic [S-1:0] qd4;
  logic [G:0]   q5;

  assign pa   = x * q_mul;
  assign pb   = x * r_mul;
  assign pm   = n2 * m_mul;
  assign pd   = qe3 * d;
  assign diff = n4 - qd4;
  assign rem  = diff[G+1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      // whole part and remainder products
      a1 <= pa[W-1:0];
      b1 <= pb;
      // add rounding half
      a2 <= a1;
      n2 <= S'(b1) + S'(h);
      // reciprocal estimate, low by at most one
      a3  <= a2;
      n3  <= n2;
      qe3 <= pm[2*S-1:S];
      // back-multiply
      a4  <= a3;
      n4  <= n3;
      qe4 <= qe3;
      qd4 <= pd[S-1:0];
      // correct the estimate
      a5 <= a4;
      q5 <= qe4[G:0] + ((rem >= {1'b0, d}) ? (G+1)'(1) : (G+1)'(0));
      // final sum
      out <= a5 + W'(q5);
    end
  end

endmodule

`default_nettype wire

/* sv/uvs_cordic.sv */
// ---------------------------------------------------------------------------
// uvs_cordic: pipelined rotation-mode sine and cosine
// One stage per CORDIC step on the angle within its quadrant, then the
// quadrant is folded back in. Results are Q30.
// ---------------------------------------------------------------------------
`default_nettype none

module uvs_cordic (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic [uvs_pkg::ANG_W-1:0]         ang,
  output logic signed [uvs_pkg::CW-1:0]          sin_out,
  output logic signed [uvs_pkg::CW-1:0]          cos_out
);

  localparam int N  = uvs_pkg::CORDIC_STEPS;
  localparam int CW = uvs_pkg::CW;

  logic signed [CW-1:0] xs [0:N];
  logic signed [CW-1:0] ys [0:N];
  logic signed [CW-1:0] zs [0:N-1];
  logic [1:0]           qs [0:N];

  // load: angle within quadrant
  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= uvs_pkg::CORDIC_GAIN;
      ys[0] <= '0;
      zs[0] <= {3'b000, ang[29:0]};
      qs[0] <= ang[31:30];
    end
  end

  // micro-rotations
  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic signed [CW-1:0] AT = CW'(uvs_pkg::atan_turn(k));
    always_ff @(posedge clk) begin
      if (en) begin
        qs[k+1] <= qs[k];
        if (!zs[k][CW-1]) begin
          xs[k+1] <= xs[k] - (ys[k] >>> k);
          ys[k+1] <= ys[k] + (xs[k] >>> k);
        end else begin
          xs[k+1] <= xs[k] + (ys[k] >>> k);
          ys[k+1] <= ys[k] - (xs[k] >>> k);
        end
      end
    end
    if (k < N - 1) begin : g_z
      always_ff @(posedge clk) begin
        if (en) zs[k+1] <= zs[k][CW-1] ? (zs[k] + AT) : (zs[k] - AT);
      end
    end
  end

  // quadrant fold
  always_ff @(posedge clk) begin
    if (en) begin
      case (qs[N])
        2'd0: begin cos_out <= xs[N];  sin_out <= ys[N];  end
        2'd1: begin cos_out <= -ys[N]; sin_out <= xs[N];  end
        2'd2: begin cos_out <= -xs[N]; sin_out <= -ys[N]; end
        default: begin cos_out <= ys[N]; sin_out <= -xs[N]; end
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/uv_sphere_vertex_generator_unit.sv */
// ---------------------------------------------------------------------------
// uv_sphere_vertex_generator_unit: UV-sphere grid point to vertex record
// Position (= normal), texture coordinates and quad indices per grid point.
// ---------------------------------------------------------------------------
//  channel  | dir | kind        | payload
//  vtx_req  | in  | valid/ready | stack_index, slice_index
//  vtx_rsp  | out | valid/ready | pos_x/y/z, tex_u/v, vertex_number, quad_*
//  apb      | in  | APB write   | stack_count @0x0, slice_count @0x4
//
//  One request per cycle, unless the full skid entry or the reciprocal setup holds vtx_req.ready low.
//  Depth is set by the index quotient lanes (6), the 32-stage CORDICs and
//  the product and rounding stages.
//  After reset and after each count write, vtx_req.ready stays low while the
//  serial reciprocal setup runs.
//  A two-entry output (result register plus skid) keeps the pipeline taking
//  requests after the result side stalls, until the skid entry fills; nothing is dropped.
// ---------------------------------------------------------------------------
`default_nettype none

module uv_sphere_vertex_generator_unit #(
  parameter int GRID_BITS = uvs_pkg::GRID_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  uvs_req_if.sink          vtx_req,
  uvs_rsp_if.source        vtx_rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int G      = GRID_BITS;
  localparam int S      = 2 * G + 2;
  localparam int IDX_W  = uvs_pkg::IDX_W;
  localparam int TEX_W  = uvs_pkg::TEX_W;
  localparam int CW     = uvs_pkg::CW;
  localparam int PROD_W = uvs_pkg::PROD_W;
  localparam int LAT    = 40;
  localparam int SIDE_N = 39;
  localparam int TEX_N  = 34;

  // ---------------- configuration registers ----------------
  logic [G-1:0] stack_count, slice_count;
  logic [G-1:0] stack_eff, slice_eff;
  logic         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_count <= G'(uvs_pkg::STACK_RESET);
      slice_count <= G'(uvs_pkg::SLICE_RESET);
    end else if (cfg_wr) begin
      if (paddr[2]) slice_count <= pwdata[G-1:0];
      else          stack_count <= pwdata[G-1:0];
    end
  end

  assign prdata    = paddr[2] ? 32'(slice_count) : 32'(stack_count);
  assign stack_eff = (stack_count == '0) ? G'(1) : stack_count;
  assign slice_eff = (slice_count == '0) ? G'(1) : slice_count;

  // ---------------- reciprocal setup ----------------
  logic               busy;
  logic [31:0]        st_qhi, sl_qhi;
  logic [G:0]         st_rhi, sl_rhi, st_rtex, sl_rtex;
  logic [TEX_W-1:0]   st_qtex, sl_qtex;
  logic [S-1:0]       st_m, sl_m;
  logic [G:0]         d_st, d_sl;

  assign d_st = {stack_eff, 1'b0};
  assign d_sl = {slice_eff, 1'b0};

  uvs_recip #(.GRID_BITS(G)) u_recip (
    .clk(clk), .rst(rst), .start(cfg_wr),
    .stack_eff(stack_eff), .slice_eff(slice_eff), .busy(busy),
    .st_qhi(st_qhi), .st_rhi(st_rhi), .st_qtex(st_qtex), .st_rtex(st_rtex), .st_m(st_m),
    .sl_qhi(sl_qhi), .sl_rhi(sl_rhi), .sl_qtex(sl_qtex), .sl_rtex(sl_rtex), .sl_m(sl_m)
  );

  // ---------------- flow control ----------------
  logic         en, accept;
  logic [LAT:0] vld;
  logic         ov, sv;
  logic         push, pop;
  uvs_pkg::rsp_t obuf, sbuf, nd;

  assign en            = !sv;
  assign vtx_req.ready = en && !busy;
  assign accept        = vtx_req.valid && vtx_req.ready;
  assign push          = en && vld[LAT];
  assign pop           = ov && vtx_rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-1:0], accept};
  end

  // ---------------- stage 0/1/2: index math ----------------
  logic [G-1:0]     i0, j0, j1;
  logic [2*G:0]     pr;
  logic [IDX_W-1:0] pr1;
  logic             oor1, qv1;
  uvs_pkg::side_t   side_pipe [0:SIDE_N-1];

  assign pr = i0 * ({1'b0, slice_eff} + (G+1)'(1));

  always_ff @(posedge clk) begin
    if (en) begin
      i0   <= vtx_req.stack_index;
      j0   <= vtx_req.slice_index;
      pr1  <= IDX_W'(pr);
      j1   <= j0;
      oor1 <= (i0 > stack_eff) || (j0 > slice_eff);
      qv1  <= (i0 < stack_eff) && (j0 < slice_eff);
      side_pipe[0].vnum   <= pr1 + IDX_W'(j1);
      side_pipe[0].qlow   <= pr1 + IDX_W'(j1) + IDX_W'(slice_eff) + IDX_W'(1);
      side_pipe[0].qvalid <= qv1;
      side_pipe[0].oor    <= oor1;
      for (int k = 1; k < SIDE_N; k++) side_pipe[k] <= side_pipe[k-1];
    end
  end

  // ---------------- quotient lanes (stages 1..6) ----------------
  logic [31:0]      phi, theta;
  logic [TEX_W-1:0] tv, tu;
  uvs_pkg::tex_t    tex_pipe [0:TEX_N-1];

  uvs_quot_lane #(.GRID_BITS(G), .QW(32), .W(32)) u_phi (
    .clk(clk), .en(en), .x(i0), .q_mul(st_qhi), .r_mul(st_rhi), .d(d_st),
    .h(stack_eff), .m_mul(st_m), .out(phi));

  uvs_quot_lane #(.GRID_BITS(G), .QW(32), .W(32)) u_theta (
    .clk(clk), .en(en), .x(j0), .q_mul(sl_qhi), .r_mul(sl_rhi), .d(d_sl),
    .h(slice_eff), .m_mul(sl_m), .out(theta));

  uvs_quot_lane #(.GRID_BITS(G), .QW(TEX_W), .W(TEX_W)) u_texv (
    .clk(clk), .en(en), .x(i0), .q_mul(st_qtex), .r_mul(st_rtex), .d(d_st),
    .h(stack_eff), .m_mul(st_m), .out(tv));

  uvs_quot_lane #(.GRID_BITS(G), .QW(TEX_W), .W(TEX_W)) u_texu (
    .clk(clk), .en(en), .x(j0), .q_mul(sl_qtex), .r_mul(sl_rtex), .d(d_sl),
    .h(slice_eff), .m_mul(sl_m), .out(tu));

  always_ff @(posedge clk) begin
    if (en) begin
      tex_pipe[0].u <= tu;
      tex_pipe[0].v <= tv;
      for (int k = 1; k < TEX_N; k++) tex_pipe[k] <= tex_pipe[k-1];
    end
  end

  // ---------------- sine/cosine (stages 7..38) ----------------
  logic signed [CW-1:0] sp, cp, stt, ct;

  uvs_cordic u_cordic_phi (.clk(clk), .en(en), .ang(phi), .sin_out(sp), .cos_out(cp));
  uvs_cordic u_cordic_theta (.clk(clk), .en(en), .ang(theta), .sin_out(stt), .cos_out(ct));

  // ---------------- products and rounding (stages 39, 40) ----------------
  logic signed [PROD_W-1:0] px39, pz39;
  logic signed [CW-1:0]     cy39;
  logic [uvs_pkg::POS_W-1:0] rx40, ry40, rz40;

  always_ff @(posedge clk) begin
    if (en) begin
      px39 <= sp * ct;
      pz39 <= sp * stt;
      cy39 <= cp;
      rx40 <= uvs_pkg::round_q14(px39, 46);
      rz40 <= uvs_pkg::round_q14(pz39, 46);
      ry40 <= uvs_pkg::round_q14({{(PROD_W-CW){cy39[CW-1]}}, cy39}, 16);
    end
  end

  // ---------------- result assembly ----------------
  always_comb begin
    nd = '0;
    nd.out_of_range = side_pipe[SIDE_N-1].oor;
    if (!side_pipe[SIDE_N-1].oor) begin
      nd.pos_x         = rx40;
      nd.pos_y         = ry40;
      nd.pos_z         = rz40;
      nd.tex_u         = tex_pipe[TEX_N-1].u;
      nd.tex_v         = tex_pipe[TEX_N-1].v;
      nd.vertex_number = side_pipe[SIDE_N-1].vnum;
      if (side_pipe[SIDE_N-1].qvalid) begin
        nd.quad_upper = side_pipe[SIDE_N-1].vnum;
        nd.quad_lower = side_pipe[SIDE_N-1].qlow;
        nd.quad_valid = 1'b1;
      end
    end
  end

  // result register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (!ov || pop) begin
      if (sv) begin
        ov <= 1'b1;
        sv <= 1'b0;
      end else begin
        ov <= push;
      end
    end else if (push) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ov || pop) begin
      obuf <= sv ? sbuf : nd;
    end else if (push) begin
      sbuf <= nd;
    end
  end

  assign vtx_rsp.valid         = ov;
  assign vtx_rsp.pos_x         = obuf.pos_x;
  assign vtx_rsp.pos_y         = obuf.pos_y;
  assign vtx_rsp.pos_z         = obuf.pos_z;
  assign vtx_rsp.tex_u         = obuf.tex_u;
  assign vtx_rsp.tex_v         = obuf.tex_v;
  assign vtx_rsp.vertex_number = obuf.vertex_number;
  assign vtx_rsp.quad_upper    = obuf.quad_upper;
  assign vtx_rsp.quad_lower    = obuf.quad_lower;
  assign vtx_rsp.quad_valid    = obuf.quad_valid;
  assign vtx_rsp.out_of_range  = obuf.out_of_range;

  // ---------------- assertions ----------------
  // a count write blocks requests while the reciprocals are rebuilt
  assert property (@(posedge clk) disable iff (rst) cfg_wr |=> !vtx_req.ready)
    else $error("request taken right after a count write");

  // skid entry only fills behind a held result
  assert property (@(posedge clk) disable iff (rst) sv |-> ov)
    else $error("skid entry valid without result register");

  // out-of-range result carries no geometry
  assert property (@(posedge clk) disable iff (rst)
      (vtx_rsp.valid && vtx_rsp.out_of_range) |->
      (vtx_rsp.pos_x == '0 && vtx_rsp.pos_y == '0 && vtx_rsp.quad_valid == 1'b0))
    else $error("out-of-range result with nonzero fields");

  // quad corner a is the vertex itself
  assert property (@(posedge clk) disable iff (rst)
      (vtx_rsp.valid && vtx_rsp.quad_valid) |->
      (vtx_rsp.quad_upper == vtx_rsp.vertex_number))
    else $error("quad corner a differs from vertex number");

endmodule

`default_nettype wire

/* dv/tb_uv_sphere_vertex_generator_unit.sv */
// ---------------------------------------------------------------------------
// tb_uv_sphere_vertex_generator_unit: self-checking bench of the vertex unit
// Drives grid point requests through valid/ready, programs the stack and
// slice counts over APB between phases, and checks every vertex record
// against a CORDIC-based vertex predictor, field by field, in order.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_uv_sphere_vertex_generator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GB         = 10;
  localparam int GMASK      = (1 << GB) - 1;
  localparam int CYC_LIMIT  = 300000;
  localparam int DRAIN_CYC  = 60;
  localparam int ITEMS_PER_PHASE = 155;
  localparam logic [2:0] ADDR_STACK = 3'd0;
  localparam logic [2:0] ADDR_SLICE = 3'd4;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  uvs_req_if #(.GRID_BITS(GB)) req_bus ();
  uvs_rsp_if rsp_bus ();

  uv_sphere_vertex_generator_unit #(.GRID_BITS(GB)) dut (
    .clk(clk), .rst(rst), .vtx_req(req_bus), .vtx_rsp(rsp_bus),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock, 4 ns period
  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  // arctangent steps as binary angles
  localparam longint ATAN_STEP [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1};

  int unsigned   stack_cfg, slice_cfg;
  uvs_pkg::rsp_t vertex_q[$];
  int            mismatches;
  int            cycles;
  int            idle_mode;       // 0: sender 13/rcv 69, 1: swapped, 2: none
  int            results_seen;
  bit            hold_done;
  int            hold_left;

  // sin/cos in Q30 of a 32-bit binary angle
  function automatic void sin_cos(input logic [31:0] ang, output longint s,
                                  output longint c);
    longint x, y, z, dx, dy;
    x = 652032874; y = 0; z = longint'(ang[29:0]);
    for (int k = 0; k < 30; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_STEP[k];
      end else begin
        x += dx; y -= dy; z += ATAN_STEP[k];
      end
    end
    case (ang[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic logic [15:0] to_q14(input longint v, input int frac);
    longint r;
    int sh;
    sh = frac - 14;
    r = (v + (longint'(1) <<< (sh - 1))) >>> sh;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  // vertex record predicted for grid point (i, j) under the current counts
  function automatic uvs_pkg::rsp_t predict_vertex(input int unsigned i,
                                                   input int unsigned j);
    uvs_pkg::rsp_t r;
    longint st, sl, sp, cp, stt, ct;
    longint phi, theta, vn;
    r = '0;
    st = (stack_cfg == 0) ? 1 : stack_cfg;
    sl = (slice_cfg == 0) ? 1 : slice_cfg;
    if (i > st || j > sl) begin
      r.out_of_range = 1'b1;
      return r;
    end
    phi   = ((longint'(i) <<< 32) + st) / (2 * st);
    theta = ((longint'(j) <<< 33) + sl) / (2 * sl);
    sin_cos(phi[31:0], sp, cp);
    sin_cos(theta[31:0], stt, ct);
    r.pos_x = to_q14(sp * ct, 60);
    r.pos_y = to_q14(cp, 30);
    r.pos_z = to_q14(sp * stt, 60);
    r.tex_u = uvs_pkg::TEX_W'(((longint'(j) <<< 17) + sl) / (2 * sl));
    r.tex_v = uvs_pkg::TEX_W'(((longint'(i) <<< 17) + st) / (2 * st));
    vn = (i * (sl + 1) + j) & 20'hFFFFF;
    r.vertex_number = vn[19:0];
    if (i < st && j < sl) begin
      r.quad_upper = vn[19:0];
      r.quad_lower = uvs_pkg::IDX_W'(vn + sl + 1);
      r.quad_valid = 1'b1;
    end
    return r;
  endfunction

  // timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: ready with random stalls and one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_bus.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 200) begin
      rsp_bus.ready <= 1'b0;
      hold_done <= 1'b1;
      hold_left <= 300;
    end else begin
      case (idle_mode)
        0: rsp_bus.ready <= ($urandom_range(99) >= 69);
        1: rsp_bus.ready <= ($urandom_range(99) >= 13);
        default: rsp_bus.ready <= 1'b1;
      endcase
    end
  end

  task automatic check_field(input string name, input logic [19:0] e,
                             input logic [19:0] g);
    if (e !== g) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected 0x%0h, got 0x%0h", name, e, g);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    uvs_pkg::rsp_t e;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      results_seen <= results_seen + 1;
      if (vertex_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: vertex record with none pending");
      end else begin
        e = vertex_q.pop_front();
        check_field("pos_x", 20'(e.pos_x), 20'(rsp_bus.pos_x));
        check_field("pos_y", 20'(e.pos_y), 20'(rsp_bus.pos_y));
        check_field("pos_z", 20'(e.pos_z), 20'(rsp_bus.pos_z));
        check_field("tex_u", 20'(e.tex_u), 20'(rsp_bus.tex_u));
        check_field("tex_v", 20'(e.tex_v), 20'(rsp_bus.tex_v));
        check_field("vertex_number", e.vertex_number, rsp_bus.vertex_number);
        check_field("quad_upper", e.quad_upper, rsp_bus.quad_upper);
        check_field("quad_lower", e.quad_lower, rsp_bus.quad_lower);
        check_field("quad_valid", 20'(e.quad_valid), 20'(rsp_bus.quad_valid));
        check_field("out_of_range", 20'(e.out_of_range), 20'(rsp_bus.out_of_range));
      end
    end
  end

  // send one request; called just after a falling edge, returns after one
  task automatic send_point(input int unsigned i, input int unsigned j,
                            input bit typed, input uvs_pkg::rsp_t typed_exp);
    int pct;
    pct = (idle_mode == 0) ? 13 : (idle_mode == 1) ? 69 : 0;
    while ($urandom_range(99) < pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk);
    end
    req_bus.valid       <= 1'b1;
    req_bus.stack_index <= i[GB-1:0];
    req_bus.slice_index <= j[GB-1:0];
    do @(posedge clk); while (!req_bus.ready);
    vertex_q.insert(vertex_q.size(),
                    typed ? typed_exp : predict_vertex(i & GMASK, j & GMASK));
    @(negedge clk);
  endtask

  // APB register write, only while idle
  task automatic write_count(input logic [2:0] addr, input int unsigned val);
    req_bus.valid <= 1'b0;
    wait (vertex_q.size() == 0);
    repeat (DRAIN_CYC) @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= addr; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_STACK) stack_cfg = val & GMASK;
    else slice_cfg = val & GMASK;
  endtask

  typedef struct {
    int unsigned i, j;
    bit          typed;
  } point_row_t;

  // directed points at the reset counts (16 stacks, 32 slices);
  // typed rows lie outside the grid, so the record is just the flag
  localparam int N_DIR = 16;
  point_row_t dir_rows [N_DIR] = '{
    '{0, 0, 0}, '{16, 0, 0}, '{0, 32, 0}, '{16, 32, 0}, '{8, 8, 0},
    '{15, 31, 0}, '{8, 16, 0}, '{4, 24, 0}, '{1, 1, 0}, '{12, 5, 0},
    '{17, 0, 1}, '{0, 33, 1}, '{1023, 1023, 1}, '{1023, 0, 1},
    '{0, 1023, 1}, '{682, 341, 1}};

  int unsigned phase_stack [10] = '{1, 1023, 0, 0, 5, 3, 1023, 7, 9, 2};
  int unsigned phase_slice [10] = '{1, 1023, 0, 7, 0, 1023, 2, 3, 9, 40};

  initial begin
    uvs_pkg::rsp_t oor_rec;
    int unsigned   st, sl, i, j;
    int            sent;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    req_bus.valid = 1'b0; req_bus.stack_index = '0; req_bus.slice_index = '0;
    stack_cfg = uvs_pkg::STACK_RESET; slice_cfg = uvs_pkg::SLICE_RESET;
    mismatches = 0; cycles = 0; idle_mode = 0; results_seen = 0;
    hold_done = 0; hold_left = 0; sent = 0;
    oor_rec = '0;
    oor_rec.out_of_range = 1'b1;
    for (int k = 8; k < 10; k++) begin
      phase_stack[k] = $urandom_range(1, 60);
      phase_slice[k] = $urandom_range(1, 60);
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part
    foreach (dir_rows[r])
      send_point(dir_rows[r].i, dir_rows[r].j, dir_rows[r].typed, oor_rec);

    // random phases over several count settings
    for (int p = 0; p < 10; p++) begin
      write_count(ADDR_STACK, phase_stack[p]);
      write_count(ADDR_SLICE, phase_slice[p]);
      st = (stack_cfg == 0) ? 1 : stack_cfg;
      sl = (slice_cfg == 0) ? 1 : slice_cfg;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        idle_mode = (sent < 520) ? 0 : (sent < 1040) ? 1 : 2;
        if ($urandom_range(99) < 80) begin
          i = $urandom_range(0, (st + 1 > GMASK) ? GMASK : st + 1);
          j = $urandom_range(0, (sl + 1 > GMASK) ? GMASK : sl + 1);
        end else begin
          i = $urandom_range(0, GMASK);
          j = $urandom_range(0, GMASK);
        end
        send_point(i, j, 1'b0, oor_rec);
        sent++;
      end
    end
    req_bus.valid <= 1'b0;

    // drain
    wait (vertex_q.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

/* uv_sphere_vertex_generator_unit.f */
sv/uvs_pkg.sv
sv/uvs_if.sv
sv/uvs_recip.sv
sv/uvs_quot_lane.sv
sv/uvs_cordic.sv
sv/uv_sphere_vertex_generator_unit.sv
dv/tb_uv_sphere_vertex_generator_unit.sv
